// ===== design/pft_pkg.sv =====
// package for the page/frame table block: action codes, word types
// no dependencies
`default_nettype none
package pft_pkg;
   localparam logic [2:0] ACT_ACCESS    = 3'd0;
   localparam logic [2:0] ACT_LOAD      = 3'd1;
   localparam logic [2:0] ACT_EVICT     = 3'd2;
   localparam logic [2:0] ACT_CLEAR_REF = 3'd3;
   localparam logic [2:0] ACT_FIND_FREE = 3'd4;
   localparam logic [2:0] ACT_READ      = 3'd5;

   typedef struct packed {
      logic [2:0]  action;
      logic [11:0] page;
      logic [5:0]  frame;
      logic        is_write;
      logic [31:0] time_req;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [5:0]  frame_out;
      logic        found;
      logic [11:0] owner_page;
      logic        referenced;
      logic        modified;
      logic [31:0] last_time;
   } rsp_type;
endpackage
`default_nettype wire

// ===== design/pft_front.sv =====
// front end: request skid queue (two entries) feeding the back end
// depends on pft_pkg
`default_nettype none
module pft_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire pft_pkg::req_type req_word,
   output logic                 q_valid,
   input  wire logic            q_ready,
   output pft_pkg::req_type     q_word
);
   pft_pkg::req_type mem_ff [2];
   logic rd_ptr_ff, wr_ptr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_word    = mem_ff[rd_ptr_ff];
   assign push = req_valid && req_ready;
   assign pop  = q_valid && q_ready;

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= req_word;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// ===== design/pft_back.sv =====
// back end: page table memory, frame memories and flag registers, execution
// depends on pft_pkg
`default_nettype none
module pft_back #(
   parameter int NUM_PAGES   = 4096,
   parameter int FRAME_COUNT = 64,
   parameter int TIME_BITS   = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [6:0]       csr_wdata,
   input  wire logic             q_valid,
   output logic                  q_ready,
   input  wire pft_pkg::req_type q_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pft_pkg::rsp_type      rsp_word
);
   localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int TB = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam int CLR_N = (NUM_PAGES > FRAME_COUNT) ? NUM_PAGES : FRAME_COUNT;
   localparam int CW = $clog2(CLR_N);

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT} state_type;

   // page table: one entry per page holds {valid, frame}
   logic [FW:0]   ptab_mem [NUM_PAGES];
   logic [FW:0]   ptab_rd_ff;

   // frame payloads in memories, flags in registers for the scans
   logic [11:0]   owner_mem [FRAME_COUNT];
   logic [TB-1:0] stamp_mem [FRAME_COUNT];
   logic [11:0]   owner_rd_ff;
   logic [TB-1:0] stamp_rd_ff;
   logic [FRAME_COUNT-1:0] occ_ff, ref_ff, mod_ff;
   logic [6:0]    fiu_ff;

   // clearing pass after reset
   logic          clr_busy_ff;
   logic [CW-1:0] clr_idx_ff;

   state_type        state_ff;
   pft_pkg::req_type cur_ff;
   pft_pkg::rsp_type out_ff;

   logic take;
   logic page_ok, frame_ok, owner_ok, hit, pvalid_rd;
   logic [PW-1:0] pidx;
   logic [FW-1:0] fidx, own_idx;
   logic [FRAME_COUNT-1:0] in_scan;
   logic ff_found;
   logic [5:0] ff_idx;
   pft_pkg::rsp_type res;

   logic          pt_we;
   logic [PW-1:0] pt_wa;
   logic [FW:0]   pt_wd;
   logic          own_we, stamp_we;
   logic [FW-1:0] fr_wa;
   logic [11:0]   fr_owner;
   logic [TB-1:0] fr_stamp;

   assign q_ready   = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign take      = q_valid && q_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_word  = out_ff;

   assign page_ok   = ({20'd0, cur_ff.page} < 32'(NUM_PAGES));
   assign frame_ok  = ({26'd0, cur_ff.frame} < 32'(FRAME_COUNT));
   assign owner_ok  = ({20'd0, owner_rd_ff} < 32'(NUM_PAGES));
   assign pidx      = PW'(cur_ff.page);
   assign fidx      = FW'(cur_ff.frame);
   assign pvalid_rd = ptab_rd_ff[FW];
   assign own_idx   = ptab_rd_ff[FW-1:0];
   assign hit       = page_ok && pvalid_rd;

   // scan window mask and lowest free frame
   always_comb begin
      ff_found = 1'b0;
      ff_idx   = 6'd0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         in_scan[i] = (32'(i) < {25'd0, fiu_ff});
      end
      for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
         if (in_scan[i] && !occ_ff[i]) begin
            ff_found = 1'b1;
            ff_idx   = 6'(i);
         end
      end
   end

   // result word
   always_comb begin
      res = '0;
      case (cur_ff.action)
         pft_pkg::ACT_ACCESS: begin
            if (hit) begin
               res.valid_res = 1'b1;
               res.frame_out = 6'(own_idx);
            end
         end
         pft_pkg::ACT_FIND_FREE: begin
            res.found     = ff_found;
            res.frame_out = ff_found ? ff_idx : 6'd0;
         end
         pft_pkg::ACT_EVICT, pft_pkg::ACT_READ: begin
            if (frame_ok) begin
               res.valid_res  = occ_ff[fidx];
               res.owner_page = owner_rd_ff;
               res.referenced = ref_ff[fidx];
               res.modified   = mod_ff[fidx];
               res.last_time  = 32'(stamp_rd_ff);
            end
         end
         default: res = '0;
      endcase
   end

   // page table write: clearing pass, load, or evict of the owner page
   always_comb begin
      pt_we = 1'b0;
      pt_wa = '0;
      pt_wd = '0;
      if (clr_busy_ff) begin
         pt_we = (32'(clr_idx_ff) < 32'(NUM_PAGES));
         pt_wa = PW'(clr_idx_ff);
      end else if (state_ff == ST_EXEC) begin
         if (cur_ff.action == pft_pkg::ACT_LOAD && page_ok && frame_ok) begin
            pt_we = 1'b1;
            pt_wa = pidx;
            pt_wd = {1'b1, fidx};
         end else if (cur_ff.action == pft_pkg::ACT_EVICT && frame_ok
                      && occ_ff[fidx] && owner_ok) begin
            pt_we = 1'b1;
            pt_wa = PW'(owner_rd_ff);
         end
      end
   end

   // frame payload write: clearing pass, load, or stamp on an access hit
   always_comb begin
      own_we   = 1'b0;
      stamp_we = 1'b0;
      fr_wa    = '0;
      fr_owner = '0;
      fr_stamp = '0;
      if (clr_busy_ff) begin
         own_we   = (32'(clr_idx_ff) < 32'(FRAME_COUNT));
         stamp_we = own_we;
         fr_wa    = FW'(clr_idx_ff);
      end else if (state_ff == ST_EXEC) begin
         if (cur_ff.action == pft_pkg::ACT_LOAD && page_ok && frame_ok) begin
            own_we   = 1'b1;
            stamp_we = 1'b1;
            fr_wa    = fidx;
            fr_owner = cur_ff.page;
            fr_stamp = TB'(cur_ff.time_req);
         end else if (cur_ff.action == pft_pkg::ACT_ACCESS && hit) begin
            stamp_we = 1'b1;
            fr_wa    = own_idx;
            fr_stamp = TB'(cur_ff.time_req);
         end
      end
   end

   // page table memory: read on accept
   always_ff @(posedge clock) begin
      if (take) ptab_rd_ff <= ptab_mem[PW'(q_word.page)];
      if (pt_we) ptab_mem[pt_wa] <= pt_wd;
   end

   // frame payload memories: read on accept
   always_ff @(posedge clock) begin
      if (take) begin
         owner_rd_ff <= owner_mem[FW'(q_word.frame)];
         stamp_rd_ff <= stamp_mem[FW'(q_word.frame)];
      end
      if (own_we) owner_mem[fr_wa] <= fr_owner;
      if (stamp_we) stamp_mem[fr_wa] <= fr_stamp;
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_idx_ff == CW'(CLR_N - 1)) clr_busy_ff <= 1'b0;
         clr_idx_ff <= clr_idx_ff + CW'(1);
      end
   end

   // control, flags and state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         ref_ff   <= '0;
         mod_ff   <= '0;
         fiu_ff   <= 7'd64;
      end else begin
         if (csr_we) fiu_ff <= csr_wdata;
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  cur_ff   <= q_word;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               out_ff   <= res;
               state_ff <= ST_OUT;
               case (cur_ff.action)
                  pft_pkg::ACT_ACCESS: begin
                     if (hit) begin
                        ref_ff[own_idx] <= 1'b1;
                        if (cur_ff.is_write) mod_ff[own_idx] <= 1'b1;
                     end
                  end
                  pft_pkg::ACT_LOAD: begin
                     if (page_ok && frame_ok) begin
                        occ_ff[fidx] <= 1'b1;
                        ref_ff[fidx] <= 1'b1;
                        mod_ff[fidx] <= 1'b0;
                     end
                  end
                  pft_pkg::ACT_EVICT: begin
                     if (frame_ok && occ_ff[fidx]) begin
                        occ_ff[fidx] <= 1'b0;
                        ref_ff[fidx] <= 1'b0;
                        mod_ff[fidx] <= 1'b0;
                     end
                  end
                  pft_pkg::ACT_CLEAR_REF: begin
                     ref_ff <= ref_ff & ~(occ_ff & in_scan);
                  end
                  default: ;
               endcase
            end
            ST_OUT: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== design/page_frame_table_rm_bits.sv =====
// page table with referenced/modified frame bits
// each word passes the back-end states table read, execute and hand-off in turn; the
// back end takes no new word until its result word is handed off (rsp_ready)
// a two-word request queue lets requests arrive while the back end is busy
// synchronous reset clears the flags, then a clearing pass over max(NUM_PAGES,
// FRAME_COUNT) entries (4096 by default) zeroes the tables before words are taken
`default_nettype none
module page_frame_table_rm_bits #(
   parameter int NUM_PAGES   = 4096,
   parameter int FRAME_COUNT = 64,
   parameter int TIME_BITS   = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pft_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pft_pkg::rsp_type      rsp_word,
   input  wire logic             csr_we,
   input  wire logic [6:0]       csr_wdata
);
   logic q_valid, q_ready;
   pft_pkg::req_type q_word;

   pft_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .q_valid, .q_ready, .q_word
   );

   pft_back #(
      .NUM_PAGES(NUM_PAGES), .FRAME_COUNT(FRAME_COUNT), .TIME_BITS(TIME_BITS)
   ) u_back (
      .clock, .reset, .csr_we, .csr_wdata,
      .q_valid, .q_ready, .q_word,
      .rsp_valid, .rsp_ready, .rsp_word
   );
endmodule
`default_nettype wire
